// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// condition never true outside reset
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) else $error(msg);

`endif

// File: sv/lrutc_pkg.sv
// ----------------------------------------------------------------------------
// lrutc_pkg
// Constants, codes and control types of the LRU tag cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lrutc_pkg;

  localparam int SLOTS      = 32;
  localparam int STAMP_BITS = 32;
  localparam int KEY_W      = 16;
  localparam int OUT_SLOT_W = 5;

  localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TREE_N    = 1 << SLOT_BITS;
  localparam int HALF_N    = TREE_N / 2;
  localparam int STEP_W    = (SLOT_BITS > 1) ? $clog2(SLOT_BITS) : 1;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_FILL   = 1'b1;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_MISS     = 2'd1,
    ST_FILLED   = 2'd2,
    ST_RESERVED = 2'd3
  } status_t;

  typedef logic [SLOT_BITS-1:0]  slot_idx_t;
  typedef logic [STAMP_BITS-1:0] stamp_t;
  typedef logic [KEY_W-1:0]      key_t;

  typedef struct packed {
    logic load_item;
    logic tree_load;
    logic tree_step;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_fill;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: sv/lrutc_ctrl.sv
// ----------------------------------------------------------------------------
// lrutc_ctrl
// Sequencer: accept, victim tree load, tree reduction, commit.
// ----------------------------------------------------------------------------
`default_nettype none

module lrutc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lrutc_pkg::dp_stat_t stat,
  output lrutc_pkg::ctl_cmd_t      cmd
);
  import lrutc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOAD   = 4'b0010,
    S_REDUCE = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.tree_load = 1'b1;
        cnt_nxt       = STEP_W'(SLOT_BITS - 2);
        if (stat.is_fill && (SLOT_BITS > 1)) begin
          state_nxt = S_REDUCE;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_REDUCE: begin
        cmd.tree_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_COMMIT;
        end else begin
          cnt_nxt = cnt_r - STEP_W'(1);
        end
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/lrutc_dpath.sv
// ----------------------------------------------------------------------------
// lrutc_dpath
// Tag/stamp storage, parallel tag match, registered min-stamp tree, result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrutc_dpath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_command,
  input  wire logic [lrutc_pkg::KEY_W-1:0]     in_key,
  input  wire lrutc_pkg::ctl_cmd_t             cmd,
  output lrutc_pkg::dp_stat_t                  stat,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [1:0]                           out_status,
  output logic [lrutc_pkg::OUT_SLOT_W-1:0]     out_slot,
  output logic                                 out_evicted_valid,
  output logic [lrutc_pkg::KEY_W-1:0]          out_evicted_key
);
  import lrutc_pkg::*;

  // item word
  logic      cmd_r;
  key_t      key_r;

  // storage
  key_t             tag_r   [SLOTS];
  stamp_t           stamp_r [SLOTS];
  logic [SLOTS-1:0] valid_r;
  stamp_t           clock_r;

  // min-stamp tree, one level per cycle
  stamp_t    red_stamp_r [HALF_N];
  slot_idx_t red_idx_r   [HALF_N];
  stamp_t    src_stamp   [TREE_N];
  slot_idx_t src_idx     [TREE_N];
  stamp_t    lvl_stamp   [HALF_N];
  slot_idx_t lvl_idx     [HALF_N];

  // result register
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [OUT_SLOT_W-1:0] out_slot_r;
  logic                  out_ev_valid_r;
  key_t                  out_ev_key_r;

  logic             reserved, is_fill, is_lookup;
  logic [SLOTS-1:0] hit_vec;
  logic             hit_any, inv_any;
  slot_idx_t        hit_idx, inv_idx, victim, res_idx;
  stamp_t           clock_inc;
  status_t          res_status;
  logic             res_ev_valid;
  key_t             res_ev_key;
  logic             out_free;

  assign reserved  = (key_r == '0);
  assign is_fill   = !reserved && (cmd_r == CMD_FILL);
  assign is_lookup = !reserved && (cmd_r == CMD_LOOKUP);
  assign out_free  = !out_valid_r || out_ready;

  assign stat.is_fill  = is_fill;
  assign stat.out_free = out_free;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit_vec[i] = valid_r[i] && (tag_r[i] == key_r);
    end
  end

  // lowest index wins
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    inv_any = 1'b0;
    inv_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_any = 1'b1;
        hit_idx = SLOT_BITS'(i);
      end
      if (!valid_r[i]) begin
        inv_any = 1'b1;
        inv_idx = SLOT_BITS'(i);
      end
    end
  end

  // tree source: stamps on load, previous level otherwise; pads never win
  always_comb begin
    for (int i = 0; i < TREE_N; i++) begin
      src_idx[i]   = SLOT_BITS'(i);
      src_stamp[i] = '1;
      if (cmd.tree_load) begin
        if (i < SLOTS) begin
          src_stamp[i] = stamp_r[i];
        end
      end else if (i < HALF_N) begin
        src_stamp[i] = red_stamp_r[i];
        src_idx[i]   = red_idx_r[i];
      end
    end
    for (int j = 0; j < HALF_N; j++) begin
      if (src_stamp[2*j+1] < src_stamp[2*j]) begin
        lvl_stamp[j] = src_stamp[2*j+1];
        lvl_idx[j]   = src_idx[2*j+1];
      end else begin
        lvl_stamp[j] = src_stamp[2*j];
        lvl_idx[j]   = src_idx[2*j];
      end
    end
  end

  assign victim    = inv_any ? inv_idx : red_idx_r[0];
  assign clock_inc = clock_r + STAMP_BITS'(1);

  always_comb begin
    res_status   = ST_FILLED;
    res_idx      = victim;
    res_ev_valid = valid_r[victim];
    res_ev_key   = tag_r[victim];
    if (reserved) begin
      res_status   = ST_RESERVED;
      res_idx      = '0;
      res_ev_valid = 1'b0;
    end else if (is_lookup) begin
      res_status   = hit_any ? ST_HIT : ST_MISS;
      res_idx      = hit_any ? hit_idx : '0;
      res_ev_valid = 1'b0;
    end
    if (!res_ev_valid) begin
      res_ev_key = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      clock_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        if (is_fill) begin
          valid_r[victim] <= 1'b1;
          clock_r         <= clock_inc;
        end else if (is_lookup && hit_any) begin
          clock_r <= clock_inc;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cmd_r <= in_command;
      key_r <= in_key;
    end
    if (cmd.tree_load || cmd.tree_step) begin
      for (int j = 0; j < HALF_N; j++) begin
        red_stamp_r[j] <= lvl_stamp[j];
        red_idx_r[j]   <= lvl_idx[j];
      end
    end
    if (cmd.commit) begin
      if (is_fill) begin
        tag_r[victim]   <= key_r;
        stamp_r[victim] <= clock_inc;
      end else if (is_lookup && hit_any) begin
        stamp_r[hit_idx] <= clock_inc;
      end
      out_status_r   <= res_status;
      out_slot_r     <= OUT_SLOT_W'(res_idx);
      out_ev_valid_r <= res_ev_valid;
      out_ev_key_r   <= res_ev_key;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot          = out_slot_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_key   = out_ev_key_r;

endmodule

`default_nettype wire

// File: sv/lru_tag_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_tag_cache_unit
// Fully associative 32-slot tag cache with timestamp LRU replacement.
//
//   Channel | Ports                                          | Dir
//   --------+------------------------------------------------+-----
//   in      | in_valid/in_ready, in_command, in_key          | in
//   out     | out_valid/out_ready, out_status, out_slot,     | out
//           | out_evicted_valid, out_evicted_key             |
//
// One word at a time. Lookup and reserved-key words pass from accept through
// the load state to commit. Fill words also pass through the reduce state,
// where the min-stamp tree reduces one level per cycle, before commit.
// The next word is accepted as soon as the result is in the output register.
// A stalled output holds the result and delays only the following commit.
// Reset clears valid bits and the access clock; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lru_tag_cache_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_command,
  input  wire logic [lrutc_pkg::KEY_W-1:0]     in_key,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [1:0]                           out_status,
  output logic [lrutc_pkg::OUT_SLOT_W-1:0]     out_slot,
  output logic                                 out_evicted_valid,
  output logic [lrutc_pkg::KEY_W-1:0]          out_evicted_key
);
  import lrutc_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  lrutc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lrutc_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_command        (in_command),
    .in_key            (in_key),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_key   (out_evicted_key)
  );

  `ASSERT_CLK(a_busy_after_accept, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "ready after accept")
  `ASSERT_NEVER(a_commit_blocked, clk, rst_n, cmd.commit && !stat.out_free, "commit into full output")
  `ASSERT_CLK(a_one_cmd, clk, rst_n, $onehot0(cmd), "multiple datapath commands")
  `ASSERT_CLK(a_commit_shows, clk, rst_n, cmd.commit |=> out_valid, "commit without result")

endmodule

`default_nettype wire
